/* rtl/core/tcae_pkg.sv */
package tcae_pkg;

    // Geometry
    localparam int ENTRIES   = 64;
    localparam int ZONE_BITS = 4;
    localparam int KEY_W     = 32 - ZONE_BITS;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    // Priority finder grouping
    localparam int GRP_SIZE  = 8;
    localparam int GRP_W     = $clog2(GRP_SIZE);
    localparam int NGRP      = (ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_W     = NGRP * GRP_SIZE;
    localparam int SUM_W     = IDX_W + GRP_W + 1;

    // Register reset value
    localparam logic [30:0] DECAY_RESET = 31'd30000;

    // Result status codes
    localparam logic [2:0] ST_HIT   = 3'd0;
    localparam logic [2:0] ST_ALLOC = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_SWEPT = 3'd3;
    localparam logic [2:0] ST_SKIP  = 3'd4;

    // Input function codes
    localparam logic FN_LOOKUP = 1'b0;
    localparam logic FN_TICK   = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_z;
        logic signed [63:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         slot_index;
        logic [7:0]         cell_offset;
        logic signed [27:0] tile_key_x;
        logic signed [27:0] tile_key_z;
        logic [6:0]         freed_count;
    } out_item_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic [KEY_W-1:0] key_x;
        logic [KEY_W-1:0] key_z;
        logic [63:0]      now;
        logic [30:0]      decay;
        logic             stamp_en;
        logic             alloc_en;
    } cell_bcast_t;

    // Sweep token and running freed count, passed cell to cell
    typedef struct packed {
        logic             token;
        logic [CNT_W-1:0] count;
    } chain_t;

endpackage

/* rtl/core/tcae_cell.sv */
module tcae_cell
    import tcae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_bcast_t bc,
    input  logic        sel,
    input  chain_t      link_in,
    output chain_t      link_out,
    output logic        valid,
    output logic        match
);

    logic             valid_reg;
    logic [KEY_W-1:0] key_x_reg;
    logic [KEY_W-1:0] key_z_reg;
    logic [63:0]      last_use_reg;
    chain_t           link_reg;
    chain_t           link_next;
    logic [63:0]      age;
    logic             expired;

    // Tag compare against the broadcast key
    assign match = valid_reg && (key_x_reg == bc.key_x) && (key_z_reg == bc.key_z);

    // Age check: negative age or above the decay time
    assign age     = bc.now - last_use_reg;
    assign expired = valid_reg && (age[63] || (age[62:0] > {32'd0, bc.decay}));

    always_comb
    begin
        link_next.token = link_in.token;
        link_next.count = link_in.count + CNT_W'(link_in.token && expired);
    end

    // Valid bit: set on allocation, cleared when the sweep token finds it expired
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && bc.alloc_en)
        begin
            valid_reg <= 1'b1;
        end
        else if (link_in.token && expired)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Tag and time stamp
    always_ff @(posedge clk)
    begin
        if (sel && bc.alloc_en)
        begin
            key_x_reg    <= bc.key_x;
            key_z_reg    <= bc.key_z;
            last_use_reg <= bc.now;
        end
        else if (sel && bc.stamp_en)
        begin
            last_use_reg <= bc.now;
        end
    end

    // Hand token and count to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;
    assign valid    = valid_reg;

endmodule

/* rtl/core/tcae_find.sv */
module tcae_find
    import tcae_pkg::*;
(
    input  logic               clk,
    input  logic [ENTRIES-1:0] req,
    output logic               found,
    output logic [IDX_W-1:0]   idx
);

    logic [PAD_W-1:0] req_pad;
    logic [NGRP-1:0]  any_reg;
    logic [GRP_W-1:0] loc_reg [NGRP];
    logic [NGRP-1:0]  any_next;
    logic [GRP_W-1:0] loc_next [NGRP];
    logic [SUM_W-1:0] sum;

    assign req_pad = PAD_W'(req);

    // First level: lowest set bit inside each group of eight
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            any_next[g] = |req_pad[g*GRP_SIZE +: GRP_SIZE];
            loc_next[g] = '0;
            for (int j = GRP_SIZE - 1; j >= 0; j--)
            begin
                if (req_pad[g*GRP_SIZE + j])
                begin
                    loc_next[g] = GRP_W'(j);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        any_reg <= any_next;
        for (int g = 0; g < NGRP; g++)
        begin
            loc_reg[g] <= loc_next[g];
        end
    end

    // Second level: lowest group that has a set bit
    always_comb
    begin
        sum = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (any_reg[g])
            begin
                sum = SUM_W'(g * GRP_SIZE) + SUM_W'(loc_reg[g]);
            end
        end
    end

    assign found = |any_reg;
    assign idx   = sum[IDX_W-1:0];

endmodule

/* rtl/core/tile_cache_with_age_eviction_top.sv */
// Channel   Signals                        Transfer when
// -------   ----------------------------   ------------------------
// input     in_valid  in_ready  in_data    in_valid && in_ready
// output    out_valid out_ready out_data   out_valid && out_ready
// config    cfg_valid cfg_ready cfg_data   cfg_valid && cfg_ready
//
// Lookup: the item registers load on transfer; the tag compare and first level
// of the two-level priority find over the entries register in S_GRP; S_SEL loads
// the result register. Tick that skips: S_SWCHK loads it. Tick that sweeps: the
// token walks the cell chain one cell a cycle, then the result register loads.
// One item is in work at a time; in_ready is high only while idle, entered from
// S_EMIT once the output register is free. A result waits in the output register;
// a stalled output holds the next result in S_EMIT. Reset clears valid bits at once.
module tile_cache_with_age_eviction_top
    import tcae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GRP   = 3'd1;
    localparam logic [2:0] S_SEL   = 3'd2;
    localparam logic [2:0] S_SWCHK = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic signed [31:0] kx_reg, kz_reg;
    logic [7:0]         off_reg;
    logic [63:0]        now_reg;
    logic [30:0]        decay_reg;
    logic [63:0]        last_sweep_reg, last_sweep_next;
    out_item_t          res_reg, res_next;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic               in_xfer;
    logic               out_free;
    logic signed [31:0] in_kx, in_kz;
    logic [31:0]        in_off;

    cell_bcast_t        bc;
    logic [ENTRIES-1:0] wr_sel;
    logic [IDX_W-1:0]   wr_idx;
    chain_t             chain [ENTRIES+1];
    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] tok_vec;
    logic               launch;

    logic               hit_found, free_found;
    logic [IDX_W-1:0]   hit_idx, free_idx;
    logic [IDX_W+5:0]   slot_wide;
    logic [CNT_W+6:0]   cnt_wide;
    logic [63:0]        sweep_gap;
    logic               sweep_due;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // Tile key and in-tile offset of the incoming coordinate
    assign in_kx  = in_data.coord_x >>> ZONE_BITS;
    assign in_kz  = in_data.coord_z >>> ZONE_BITS;
    assign in_off = 32'(in_data.coord_x[ZONE_BITS-1:0])
                  | (32'(in_data.coord_z[ZONE_BITS-1:0]) << ZONE_BITS);

    // Broadcast to cells
    assign wr_idx = hit_found ? hit_idx : free_idx;
    always_comb
    begin
        bc.key_x    = kx_reg[KEY_W-1:0];
        bc.key_z    = kz_reg[KEY_W-1:0];
        bc.now      = now_reg;
        bc.decay    = decay_reg;
        bc.stamp_en = (state_reg == S_SEL) && hit_found;
        bc.alloc_en = (state_reg == S_SEL) && !hit_found && free_found;
    end

    // Cell chain
    assign chain[0].token = launch;
    assign chain[0].count = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        assign wr_sel[i]  = (wr_idx == IDX_W'(i));
        assign tok_vec[i] = chain[i+1].token;

        tcae_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bc       (bc),
            .sel      (wr_sel[i]),
            .link_in  (chain[i]),
            .link_out (chain[i+1]),
            .valid    (valid_vec[i]),
            .match    (hit_vec[i])
        );
    end

    // Lowest matching slot and lowest free slot
    tcae_find u_find_hit (
        .clk   (clk),
        .req   (hit_vec),
        .found (hit_found),
        .idx   (hit_idx)
    );

    tcae_find u_find_free (
        .clk   (clk),
        .req   (~valid_vec),
        .found (free_found),
        .idx   (free_idx)
    );

    assign slot_wide = {6'd0, wr_idx};
    assign cnt_wide  = {7'd0, chain[ENTRIES].count};

    // Sweep interval check
    assign sweep_gap = now_reg - last_sweep_reg;
    assign sweep_due = sweep_gap[63] || (sweep_gap > {35'd0, decay_reg[30:2]});

    // Controller
    always_comb
    begin
        state_next      = state_reg;
        res_next        = res_reg;
        last_sweep_next = last_sweep_reg;
        launch          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (in_data.func == FN_TICK) ? S_SWCHK : S_GRP;
                end
            end
            S_GRP:
            begin
                state_next = S_SEL;
            end
            S_SEL:
            begin
                res_next             = '0;
                res_next.cell_offset = off_reg;
                res_next.tile_key_x  = kx_reg[27:0];
                res_next.tile_key_z  = kz_reg[27:0];
                if (hit_found)
                begin
                    res_next.status     = ST_HIT;
                    res_next.slot_index = slot_wide[5:0];
                end
                else if (free_found)
                begin
                    res_next.status     = ST_ALLOC;
                    res_next.slot_index = slot_wide[5:0];
                end
                else
                begin
                    res_next.status = ST_FULL;
                end
                state_next = S_EMIT;
            end
            S_SWCHK:
            begin
                res_next = '0;
                if (sweep_due)
                begin
                    last_sweep_next = now_reg;
                    launch          = 1'b1;
                    state_next      = S_SWEEP;
                end
                else
                begin
                    res_next.status = ST_SKIP;
                    state_next      = S_EMIT;
                end
            end
            S_SWEEP:
            begin
                if (chain[ENTRIES].token)
                begin
                    res_next             = '0;
                    res_next.status      = ST_SWEPT;
                    res_next.freed_count = cnt_wide[6:0];
                    state_next           = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            decay_reg      <= DECAY_RESET;
            last_sweep_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_sweep_reg <= last_sweep_next;
            if (cfg_valid && cfg_ready)
            begin
                decay_reg <= cfg_data;
            end
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_xfer)
        begin
            kx_reg  <= in_kx;
            kz_reg  <= in_kz;
            off_reg <= in_off[7:0];
            now_reg <= in_data.now_time;
        end
        if (state_reg == S_EMIT && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // At most one sweep token in the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one sweep token in the cell chain");

    // Tokens only travel while a sweep is in progress
    a_token_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SWEEP) |-> (tok_vec == '0))
        else $error("sweep token outside a sweep");

    // Valid entries hold distinct keys
    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("tile key held by more than one entry");

    // Allocation always lands in a free slot
    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        bc.alloc_en |-> !valid_vec[free_idx])
        else $error("allocation into a valid slot");

    // Allocated slot is valid afterwards
    a_alloc_sets: assert property (@(posedge clk) disable iff (!rst_n)
        bc.alloc_en |=> valid_vec[$past(free_idx)])
        else $error("allocated slot not marked valid");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import tcae_pkg::*;

    localparam int POOL_SIZE      = 72;
    localparam int SETTLE_CYCLES  = ENTRIES + 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 40;
    localparam logic [31:0] OFF_MASK = (32'd1 << ZONE_BITS) - 32'd1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // DUT connections
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [30:0] cfg_data  = '0;

    // Stimulus and scoreboard storage
    in_item_t    tile_requests[$];
    out_item_t   tile_results_due[$];
    int          requests_queued = 0;
    int          requests_taken  = 0;
    int          results_checked = 0;
    int          mismatch_count  = 0;
    int          quiet_cycles    = 0;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    out_item_t   want;

    // Shadow copy of the cache tags, ages and the decay register
    logic              slot_used  [ENTRIES];
    logic [KEY_W-1:0]  slot_kx    [ENTRIES];
    logic [KEY_W-1:0]  slot_kz    [ENTRIES];
    logic [63:0]       slot_stamp [ENTRIES];
    logic [63:0]       sweep_stamp;
    logic [30:0]       decay_model;

    tile_cache_with_age_eviction_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Signed 64-bit age test: negative, or above the limit
    function automatic bit age_exceeds(logic [63:0] later, logic [63:0] earlier,
                                       logic [63:0] limit);
        logic [63:0] d;
        d = later - earlier;
        return d[63] || (d > limit);
    endfunction

    // Expected result of one request; updates the shadow cache
    function automatic out_item_t compute_tile_result(in_item_t req);
        out_item_t        res;
        logic [KEY_W-1:0] kx;
        logic [KEY_W-1:0] kz;
        logic [31:0]      off;
        int               hit_slot;
        int               free_slot;
        int               freed;
        res = '0;
        if (req.func == FN_TICK)
        begin
            if (!age_exceeds(req.now_time, sweep_stamp, {33'd0, decay_model >> 2}))
            begin
                res.status = ST_SKIP;
            end
            else
            begin
                sweep_stamp = req.now_time;
                freed = 0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_used[i] &&
                        age_exceeds(req.now_time, slot_stamp[i], {33'd0, decay_model}))
                    begin
                        slot_used[i] = 1'b0;
                        freed++;
                    end
                end
                res.status      = ST_SWEPT;
                res.freed_count = 7'(freed);
            end
        end
        else
        begin
            kx  = req.coord_x[31:ZONE_BITS];
            kz  = req.coord_z[31:ZONE_BITS];
            off = (req.coord_x & OFF_MASK) | ((req.coord_z & OFF_MASK) << ZONE_BITS);
            hit_slot  = -1;
            free_slot = -1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot_used[i])
                begin
                    if (hit_slot < 0 && slot_kx[i] == kx && slot_kz[i] == kz)
                        hit_slot = i;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            res.cell_offset = off[7:0];
            res.tile_key_x  = kx;
            res.tile_key_z  = kz;
            if (hit_slot >= 0)
            begin
                slot_stamp[hit_slot] = req.now_time;
                res.status     = ST_HIT;
                res.slot_index = 6'(hit_slot);
            end
            else if (free_slot >= 0)
            begin
                slot_used[free_slot]  = 1'b1;
                slot_kx[free_slot]    = kx;
                slot_kz[free_slot]    = kz;
                slot_stamp[free_slot] = req.now_time;
                res.status     = ST_ALLOC;
                res.slot_index = 6'(free_slot);
            end
            else
            begin
                res.status = ST_FULL;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want_v);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH at result %0d: %s: got 0x%0h, expected 0x%0h",
                     results_checked, what, got, want_v);
        mismatch_count++;
    endtask

    task automatic queue_request(input logic fn, input logic [31:0] x, input logic [31:0] z,
                                 input logic [63:0] t);
        in_item_t req;
        req.func     = fn;
        req.coord_x  = x;
        req.coord_z  = z;
        req.now_time = t;
        tile_requests = {tile_requests, req};
        requests_queued++;
    endtask

    // Register write; called right after a rising edge while the block is idle
    task automatic set_decay_time(input logic [30:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        decay_model = v;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                send_idle_pct  = 50;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 50;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = 7;
                recv_stall_pct = 7;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Wait until every request is taken and every result is back, then settle
    task automatic wait_drained();
        do @(posedge clk);
        while (requests_taken != requests_queued || tile_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset value of the register, hits and allocations, wraparound ages
    task automatic queue_directed();
        queue_request(FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, 64'd0);
        queue_request(FN_LOOKUP, 32'h0000_000f, 32'h0000_000f, 64'd1);
        queue_request(FN_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 64'd2);
        queue_request(FN_LOOKUP, 32'h8000_0000, 32'h7fff_ffff, 64'd3);
        queue_request(FN_LOOKUP, 32'h7fff_ffff, 32'h8000_0000, 64'd4);
        queue_request(FN_LOOKUP, 32'h0000_0010, 32'h0000_0000, 64'd5);
        queue_request(FN_LOOKUP, 32'h0000_0000, 32'h0000_0010, 64'd6);
        // interval below, exactly at and just above a quarter of the decay time
        queue_request(FN_TICK,   32'h0000_0000, 32'h0000_0000, 64'd6);
        queue_request(FN_TICK,   32'h0000_0000, 32'h0000_0000, 64'd7500);
        queue_request(FN_TICK,   32'h0000_0000, 32'h0000_0000, 64'd7501);
        // stamp in the future, so its age turns negative
        queue_request(FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, 64'd40000);
        queue_request(FN_TICK,   32'hffff_ffff, 32'hffff_ffff, 64'd15002);
        queue_request(FN_LOOKUP, 32'h0000_0005, 32'h0000_0005, 64'd15003);
        queue_request(FN_TICK,   32'h0000_0000, 32'h0000_0000, 64'd100000);
        // time differences that wrap around
        queue_request(FN_LOOKUP, 32'h7fff_ffff, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff);
        queue_request(FN_TICK,   32'h0000_0000, 32'h0000_0000, 64'h8000_0000_0000_0000);
        queue_request(FN_TICK,   32'h0000_0000, 32'h0000_0000, 64'd0);
        // negative times and a negative sweep interval
        queue_request(FN_LOOKUP, 32'hffff_fff0, 32'hffff_fff0, 64'hffff_ffff_ffff_fffb);
        queue_request(FN_LOOKUP, 32'hffff_ffff, 32'hffff_fff0, 64'hffff_ffff_ffff_fffc);
        queue_request(FN_TICK,   32'h0000_0000, 32'h0000_0000, 64'hffff_ffff_ffff_fffd);
        queue_request(FN_TICK,   32'h0000_0000, 32'h0000_0000, 64'hffff_ffff_ffff_fffd);
    endtask

    // Random traffic over a pool of tile keys, slightly larger than the cache
    task automatic queue_random(input bit fill_first, input int count);
        logic [KEY_W-1:0] pool_kx [POOL_SIZE];
        logic [KEY_W-1:0] pool_kz [POOL_SIZE];
        logic [63:0]      t;
        logic [31:0]      step;
        logic [31:0]      ra;
        logic [31:0]      rb;
        logic [31:0]      rc;
        int               r;
        int               j;
        step = ({1'b0, decay_model} >> 5) + 32'd1;
        t    = {$urandom, $urandom};
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            ra = $urandom;
            rb = $urandom;
            // odd entries share x with their neighbor, so only z tells them apart
            pool_kx[k] = (k % 2 == 1) ? pool_kx[k - 1] : ra[KEY_W-1:0];
            pool_kz[k] = rb[KEY_W-1:0];
        end
        // fill every slot, overflow it, then free everything at once
        if (fill_first)
        begin
            for (int k = 0; k < POOL_SIZE; k++)
            begin
                ra = $urandom;
                t  = t + 64'($urandom_range(step, 0));
                queue_request(FN_LOOKUP, {pool_kx[k], ra[ZONE_BITS-1:0]},
                              {pool_kz[k], ra[ZONE_BITS+7:8]}, t);
            end
            t = t + {33'd0, decay_model} + 64'd1;
            ra = $urandom;
            rb = $urandom;
            queue_request(FN_TICK, ra, rb, t);
        end
        for (int n = 0; n < count; n++)
        begin
            r  = $urandom_range(99);
            j  = $urandom_range(POOL_SIZE - 1);
            ra = $urandom;
            rb = $urandom;
            rc = $urandom;
            if (r < 55)
            begin
                t = t + 64'($urandom_range(step, 0));
                queue_request(FN_LOOKUP, {pool_kx[j], ra[ZONE_BITS-1:0]},
                              {pool_kz[j], rb[ZONE_BITS-1:0]}, t);
            end
            else if (r < 65)
            begin
                t = t + 64'($urandom_range(step, 0));
                queue_request(FN_LOOKUP, ra, rb, t);
            end
            else if (r < 88)
            begin
                t = t + 64'($urandom_range(step * 8, 0));
                queue_request(FN_TICK, ra, rb, t);
            end
            else if (r < 95)
            begin
                t = t + {33'd0, decay_model} + 64'($urandom_range({1'b0, decay_model}, 0));
                queue_request(FN_TICK, ra, rb, t);
            end
            else
            begin
                // time jumps back or anywhere
                if (rc[0])
                    t = {$urandom, $urandom};
                else
                    t = t - 64'($urandom_range(step * 4, 0));
                queue_request(rc[1] ? FN_TICK : FN_LOOKUP, ra, rb, t);
            end
        end
    endtask

    // Input driver: next request from the queue, random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                tile_results_due = {tile_results_due, compute_tile_result(in_data)};
                requests_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (tile_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= tile_requests.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each output transfer with the oldest expected result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (tile_results_due.size() == 0)
            begin
                report_mismatch("result with nothing due", out_data[63:0], 64'd0);
            end
            else
            begin
                want = tile_results_due.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", 64'(out_data.status), 64'(want.status));
                if (out_data.slot_index !== want.slot_index)
                    report_mismatch("slot_index", 64'(out_data.slot_index),
                                    64'(want.slot_index));
                if (out_data.cell_offset !== want.cell_offset)
                    report_mismatch("cell_offset", 64'(out_data.cell_offset),
                                    64'(want.cell_offset));
                if (out_data.tile_key_x !== want.tile_key_x)
                    report_mismatch("tile_key_x", 64'(unsigned'(out_data.tile_key_x)),
                                    64'(unsigned'(want.tile_key_x)));
                if (out_data.tile_key_z !== want.tile_key_z)
                    report_mismatch("tile_key_z", 64'(unsigned'(out_data.tile_key_z)),
                                    64'(unsigned'(want.tile_key_z)));
                if (out_data.freed_count !== want.freed_count)
                    report_mismatch("freed_count", 64'(out_data.freed_count),
                                    64'(want.freed_count));
            end
            results_checked++;
        end
    end

    // Watchdog: cycles without any transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sequencer: reset, directed checks, then random phases with new settings
    initial
    begin
        int          p;
        logic [30:0] dv;
        logic [31:0] rw;
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_kx[i]    = '0;
            slot_kz[i]    = '0;
            slot_stamp[i] = '0;
        end
        sweep_stamp = '0;
        decay_model = DECAY_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(IDLE_NONE);
        queue_directed();
        wait_drained();

        for (p = 1; p <= 8; p++)
        begin
            case (p)
                1, 8:    dv = 31'd1;
                2, 6:    dv = 31'h7fff_ffff;
                3:       dv = DECAY_RESET;
                5:       dv = 31'd64;
                default:
                begin
                    rw = $urandom_range(32'h7fff_ffff, 1);
                    dv = rw[30:0];
                end
            endcase
            set_decay_time(dv);
            set_idling(idle_mode_t'(p % 4));
            if (p % 3 == 1)
                queue_random(1'b1, 40);
            else
                queue_random(1'b0, 115);
            wait_drained();
        end

        if (tile_results_due.size() != 0)
            report_mismatch("results never delivered", 64'(tile_results_due.size()), 64'd0);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
